>>> sv/ffts_pkg.sv
`timescale 1ns / 1ps
package ffts_pkg;

    localparam int TS_W     = 48;
    localparam int DUR_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int SERIAL_W = 32;

    localparam logic [2:0] MODE_PUSH  = 3'd0;
    localparam logic [2:0] MODE_POP   = 3'd1;
    localparam logic [2:0] MODE_PEEK  = 3'd2;
    localparam logic [2:0] MODE_DROP  = 3'd3;
    localparam logic [2:0] MODE_FLUSH = 3'd4;
    localparam logic [2:0] MODE_ABORT = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ABORT = 2'd3;

    // 0.04 s in Q16 seconds
    localparam logic [DUR_W-1:0] DUR_RESET = 16'd2621;
    localparam logic [TS_W-1:0]  TS_MAX    = {TS_W{1'b1}};

    typedef struct packed {
        logic [2:0]          mode;
        logic [HANDLE_W-1:0] frame_handle;
        logic                pts_valid;
        logic [TS_W-1:0]     pts;
        logic [SERIAL_W-1:0] serial;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] out_frame;
        logic [TS_W-1:0]     out_pts;
        logic [SERIAL_W-1:0] out_serial;
        logic                is_full;
    } t_out_item;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TS_W-1:0]     pts;
        logic [SERIAL_W-1:0] serial;
    } t_entry;

    typedef struct packed {
        logic load_in;
        logic exec;
    } t_dp_cmd;

endpackage

>>> sv/ffts_if.sv
`timescale 1ns / 1ps
interface ffts_in_if;
    import ffts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffts_out_if #(
    parameter int CNT_W = 5
);
    import ffts_pkg::*;
    logic             valid;
    logic             ready;
    t_out_item        data;
    logic [CNT_W-1:0] fill_count;
    modport source (output valid, output data, output fill_count, input ready);
    modport sink (input valid, input data, input fill_count, output ready);
endinterface

interface ffts_cfg_if;
    import ffts_pkg::*;
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/ffts_ctrl.sv
`timescale 1ns / 1ps
module ffts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output ffts_pkg::t_dp_cmd o_cmd
);
    import ffts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;

    // a new beat may enter in the idle state once the result slot is free or draining
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted beat not executed next cycle");

    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("execute while result slot occupied");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_out_valid && r_state == S_IDLE))
        else $error("execute did not produce a result");

endmodule

>>> sv/ffts_dp.sv
`timescale 1ns / 1ps
module ffts_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PTR_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ffts_pkg::t_dp_cmd                 i_cmd,
    input  ffts_pkg::t_in_item                i_in_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ffts_pkg::DUR_W-1:0]        i_cfg_data,
    output ffts_pkg::t_out_item               o_out_data,
    output logic [CNT_W-1:0]                  o_fill_count
);
    import ffts_pkg::*;

    localparam int ENTRY_W = $bits(t_entry);

    logic [ENTRY_W-1:0] r_mem [QUEUE_DEPTH];
    t_entry             r_rd_data;
    t_in_item           r_in;

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [TS_W-1:0]  r_last, n_last;
    logic             r_last_v, n_last_v;
    logic [DUR_W-1:0] r_dur, n_dur;
    logic [DUR_W-1:0] r_def_dur;
    logic             r_aborted, n_aborted;
    t_out_item        r_out, n_out;
    logic [CNT_W-1:0] r_fill;

    logic             w_we;
    t_entry           w_wr_entry;
    logic [TS_W:0]    w_sum;
    logic             w_sat;
    logic [TS_W-1:0]  w_syn_pts;
    logic [DUR_W-1:0] w_syn_delta;
    logic [TS_W:0]    w_diff;
    logic [TS_W-1:0]  w_push_pts;
    logic [DUR_W-1:0] w_delta;
    logic             w_step;
    logic             w_empty;
    logic             w_full;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_cfg_ready  = 1'b1;
    assign o_out_data   = r_out;
    assign o_fill_count = r_fill;
    assign w_empty      = (r_cnt == '0);
    assign w_full       = (r_cnt == CNT_W'(QUEUE_DEPTH));

    // synthetic timestamp: step is the duration, or what is left below saturation
    assign w_sum       = {1'b0, r_last} + {{(TS_W + 1 - DUR_W){1'b0}}, r_dur};
    assign w_sat       = w_sum[TS_W];
    assign w_syn_pts   = !r_last_v ? '0 : (w_sat ? TS_MAX : w_sum[TS_W-1:0]);
    assign w_syn_delta = w_sat ? ~r_last[DUR_W-1:0] : r_dur;

    assign w_diff = {1'b0, r_in.pts} - {1'b0, r_last};

    always_comb begin
        if (r_in.pts_valid) begin
            w_push_pts = r_in.pts;
            w_delta    = w_diff[DUR_W-1:0];
            w_step     = r_last_v && !w_diff[TS_W] && (w_diff[TS_W-1:0] != '0)
                         && (w_diff[TS_W-1:DUR_W] == '0);
        end else begin
            w_push_pts = w_syn_pts;
            w_delta    = w_syn_delta;
            w_step     = r_last_v && (w_syn_delta != '0);
        end
    end

    assign w_wr_entry = '{handle: r_in.frame_handle, pts: w_push_pts, serial: r_in.serial};

    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_last_v  = r_last_v;
        n_dur     = r_dur;
        n_aborted = r_aborted;
        n_out     = '0;
        w_we      = 1'b0;
        n_out.status = ST_DONE;
        case (r_in.mode)
            MODE_PUSH: begin
                if (r_aborted) begin
                    n_out.status = ST_ABORT;
                end else if (w_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_we          = 1'b1;
                    n_wr_ptr      = wrap_next(r_wr_ptr);
                    n_cnt         = r_cnt + CNT_W'(1);
                    n_last        = w_push_pts;
                    n_last_v      = 1'b1;
                    n_out.out_pts = w_push_pts;
                    if (w_step) begin
                        n_dur = w_delta;
                    end
                end
            end
            MODE_POP, MODE_PEEK: begin
                if (r_aborted) begin
                    n_out.status = ST_ABORT;
                end else if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.out_frame  = r_rd_data.handle;
                    n_out.out_pts    = r_rd_data.pts;
                    n_out.out_serial = r_rd_data.serial;
                    if (r_in.mode == MODE_POP) begin
                        n_rd_ptr = wrap_next(r_rd_ptr);
                        n_cnt    = r_cnt - CNT_W'(1);
                    end
                end
            end
            MODE_DROP: begin
                if (w_empty) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_rd_ptr = wrap_next(r_rd_ptr);
                    n_cnt    = r_cnt - CNT_W'(1);
                end
            end
            MODE_FLUSH: begin
                n_rd_ptr = '0;
                n_wr_ptr = '0;
                n_cnt    = '0;
                n_last_v = 1'b0;
            end
            MODE_ABORT: begin
                n_aborted = 1'b1;
            end
            default: begin
            end
        endcase
        n_out.is_full = (n_cnt == CNT_W'(QUEUE_DEPTH));
    end

    // store: one write port, one registered read port at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[r_wr_ptr] <= w_wr_entry;
        end
        r_rd_data <= t_entry'(r_mem[r_rd_ptr]);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out  <= n_out;
            r_fill <= n_cnt;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_cnt     <= '0;
            r_last_v  <= 1'b0;
            r_aborted <= 1'b0;
            r_dur     <= DUR_RESET;
            r_def_dur <= DUR_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_cnt     <= n_cnt;
                r_last_v  <= n_last_v;
                r_aborted <= n_aborted;
                r_dur     <= n_dur;
            end
            if (i_cfg_valid) begin
                r_def_dur <= i_cfg_data;
                r_dur     <= i_cfg_data;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CNT_W'(QUEUE_DEPTH)) |-> (r_rd_ptr == r_wr_ptr))
        else $error("pointers disagree with count");

    a_abort_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aborted |=> r_aborted)
        else $error("abort flag cleared without reset");

    a_dur_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_dur == r_def_dur))
        else $error("register write did not reload duration");

endmodule

>>> sv/frame_fifo_with_timestamp_fill.sv
`timescale 1ns / 1ps
// A result beat is registered when the controller executes an accepted input beat;
//   no new beat is accepted before the last one executes, by the accept/execute
//   sequence of the controller around the registered read port of the entry memory.
// Reset (synchronous, active low) clears pointers, count, last timestamp flag and
//   abort, and reloads the duration register; the entry memory is not cleared.
module frame_fifo_with_timestamp_fill #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffts_in_if.sink    i_in,
    ffts_out_if.source o_res,
    ffts_cfg_if.sink   i_cfg
);
    import ffts_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_dp_cmd w_cmd;

    ffts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (w_cmd)
    );

    ffts_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_in_data    (i_in.data),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_data   (i_cfg.data),
        .o_out_data   (o_res.data),
        .o_fill_count (o_res.fill_count)
    );

endmodule

>>> verif/frame_fifo_with_timestamp_fill_tb.sv
`timescale 1ns / 1ps
module frame_fifo_with_timestamp_fill_tb;
    import ffts_pkg::*;

    localparam int DEPTH        = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [2:0]      MODE_NOP6 = 3'd6;
    localparam logic [2:0]      MODE_NOP7 = 3'd7;
    localparam logic [TS_W-1:0] ONE_SEC   = 48'd65536;

    typedef struct packed {
        t_out_item  res;
        logic [4:0] fill;
    } t_op_result;

    typedef struct {
        t_in_item   item;
        bit         fixed;
        t_op_result want;
    } t_dir_row;

    logic clk;
    logic rst_n;

    ffts_in_if              in_if ();
    ffts_out_if #(.CNT_W(5)) res_if ();
    ffts_cfg_if             cfg_if ();

    frame_fifo_with_timestamp_fill #(
        .QUEUE_DEPTH(DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // queue state as the block should hold it
    t_entry          ent_store [DEPTH];
    logic [3:0]      rd_idx     = '0;
    logic [3:0]      wr_idx     = '0;
    logic [4:0]      held       = '0;
    logic [TS_W-1:0] last_ts    = '0;
    logic            last_ts_ok = 1'b0;
    logic [DUR_W-1:0] dur_est   = DUR_RESET;
    logic            abort_seen = 1'b0;

    t_op_result pending_results [$];
    int         err_cnt      = 0;
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;
    bit         stall_go     = 1'b0;
    logic       rx_hold;

    initial begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin : cycle_limit
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic t_op_result predict_queue_op(input t_in_item it);
        t_op_result      r;
        logic [TS_W-1:0] ts;
        logic [TS_W:0]   sum;
        logic [TS_W-1:0] step;
        r = '0;
        r.res.status = ST_DONE;
        case (it.mode)
            MODE_PUSH: begin
                if (abort_seen) begin
                    r.res.status = ST_ABORT;
                end else if (held == DEPTH) begin
                    r.res.status = ST_FULL;
                end else begin
                    ts = it.pts;
                    if (!it.pts_valid) begin
                        if (last_ts_ok) begin
                            sum = {1'b0, last_ts} + {{(TS_W - DUR_W + 1){1'b0}}, dur_est};
                            ts  = sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
                        end else begin
                            ts = '0;
                        end
                    end
                    // only a forward step under one second retunes the estimate
                    if (last_ts_ok && ts > last_ts) begin
                        step = ts - last_ts;
                        if (step < ONE_SEC) dur_est = step[DUR_W-1:0];
                    end
                    last_ts    = ts;
                    last_ts_ok = 1'b1;
                    ent_store[wr_idx] = '{handle: it.frame_handle, pts: ts, serial: it.serial};
                    wr_idx = wr_idx + 4'd1;
                    held   = held + 5'd1;
                    r.res.out_pts = ts;
                end
            end
            MODE_POP, MODE_PEEK: begin
                if (abort_seen) begin
                    r.res.status = ST_ABORT;
                end else if (held == 0) begin
                    r.res.status = ST_EMPTY;
                end else begin
                    r.res.out_frame  = ent_store[rd_idx].handle;
                    r.res.out_pts    = ent_store[rd_idx].pts;
                    r.res.out_serial = ent_store[rd_idx].serial;
                    if (it.mode == MODE_POP) begin
                        rd_idx = rd_idx + 4'd1;
                        held   = held - 5'd1;
                    end
                end
            end
            MODE_DROP: begin
                if (held == 0) begin
                    r.res.status = ST_EMPTY;
                end else begin
                    rd_idx = rd_idx + 4'd1;
                    held   = held - 5'd1;
                end
            end
            MODE_FLUSH: begin
                rd_idx     = '0;
                wr_idx     = '0;
                held       = '0;
                last_ts_ok = 1'b0;
            end
            MODE_ABORT: abort_seen = 1'b1;
            default: ;
        endcase
        r.fill       = held;
        r.res.is_full = (held == DEPTH);
        return r;
    endfunction

    function automatic t_in_item op(input logic [2:0] mode, input logic [31:0] handle,
                                    input logic pv, input logic [TS_W-1:0] pts,
                                    input logic [31:0] serial);
        t_in_item it;
        it.mode         = mode;
        it.frame_handle = handle;
        it.pts_valid    = pv;
        it.pts          = pts;
        it.serial       = serial;
        return it;
    endfunction

    function automatic t_dir_row row_pred(input t_in_item it);
        t_dir_row d;
        d.item  = it;
        d.fixed = 1'b0;
        d.want  = '0;
        return d;
    endfunction

    function automatic t_dir_row row_lit(input t_in_item it, input logic [1:0] st,
                                         input logic [TS_W-1:0] pts, input int fill);
        t_dir_row d;
        d.item             = it;
        d.fixed            = 1'b1;
        d.want             = '0;
        d.want.res.status  = st;
        d.want.res.out_pts = pts;
        d.want.res.is_full = (fill == DEPTH);
        d.want.fill        = fill[4:0];
        return d;
    endfunction

    function automatic logic [TS_W-1:0] pick_pts();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return last_ts + TS_W'($urandom_range(1, 65535));
            4:          return last_ts + ONE_SEC + TS_W'($urandom_range(0, 2));
            5:          return raw[TS_W-1:0];
            6:          return TS_MAX - TS_W'($urandom_range(0, 70000));
            7:          return last_ts - TS_W'($urandom_range(0, 3000));
            8:          return TS_W'($urandom_range(0, 200));
            default:    return last_ts;
        endcase
    endfunction

    // push_pct steers the fill level: high values run the queue into full
    function automatic t_in_item random_op(input int push_pct);
        t_in_item   it;
        logic [2:0] mode;
        int         q;
        if ($urandom_range(0, 99) < push_pct) begin
            mode = MODE_PUSH;
        end else begin
            q = $urandom_range(0, 99);
            if (q < 45)      mode = MODE_POP;
            else if (q < 65) mode = MODE_PEEK;
            else if (q < 85) mode = MODE_DROP;
            else if (q < 93) mode = MODE_FLUSH;
            else             mode = $urandom_range(0, 1) ? MODE_NOP6 : MODE_NOP7;
        end
        it = op(mode, $urandom, 1'($urandom_range(0, 1)), pick_pts(), $urandom);
        return it;
    endfunction

    task automatic send_op(input t_in_item it, input bit fixed, input t_op_result want);
        t_op_result pred;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        pred = predict_queue_op(it);
        pending_results.push_back(fixed ? want : pred);
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_duration(input logic [DUR_W-1:0] v);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        dur_est = v;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n_ops, input int tx_pct, input int rx_pct);
        int bias;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        for (int k = 0; k < n_ops; k++) begin
            bias = ((k / 48) % 2 == 0) ? 68 : 32;
            send_op(random_op(bias), 1'b0, '0);
            if ($urandom_range(0, 149) == 0) drain_results();
        end
        drain_results();
    endtask

    initial begin : res_ready_drive
        res_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            res_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin : rx_holdoff
        rx_hold = 1'b0;
        wait (stall_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    function automatic void cmp_field(input string fname, input logic [63:0] want,
                                      input logic [63:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, fname, want, got);
        end
    endfunction

    initial begin : result_check
        t_op_result w;
        forever begin
            @(posedge clk);
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t ns: unexpected result beat: expected none, actual status %h",
                             $time, res_if.data.status);
                end else begin
                    w = pending_results.pop_front();
                    cmp_field("status", w.res.status, res_if.data.status);
                    cmp_field("out_frame", w.res.out_frame, res_if.data.out_frame);
                    cmp_field("out_pts", w.res.out_pts, res_if.data.out_pts);
                    cmp_field("out_serial", w.res.out_serial, res_if.data.out_serial);
                    cmp_field("fill_count", w.fill, res_if.fill_count);
                    cmp_field("is_full", w.res.is_full, res_if.data.is_full);
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row head_rows [$];
        t_dir_row tail_rows [$];

        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rst_n        = 1'b0;

        // empty queue right after reset
        head_rows.push_back(row_lit(op(MODE_POP, 0, 0, 0, 0), ST_EMPTY, 0, 0));
        head_rows.push_back(row_lit(op(MODE_PEEK, 0, 0, 0, 0), ST_EMPTY, 0, 0));
        head_rows.push_back(row_lit(op(MODE_DROP, 0, 0, 0, 0), ST_EMPTY, 0, 0));
        // missing timestamp with no history fills zero
        head_rows.push_back(row_lit(op(MODE_PUSH, 32'hFFFF_FFFF, 0, 48'h1234, 32'hFFFF_FFFF),
                                    ST_DONE, 0, 1));
        head_rows.push_back(row_pred(op(MODE_PUSH, 0, 1, TS_MAX - 48'd100, 0)));
        // fill saturates at the top of the range
        head_rows.push_back(row_lit(op(MODE_PUSH, 1, 0, 0, 1), ST_DONE, TS_MAX, 3));
        head_rows.push_back(row_pred(op(MODE_PUSH, 2, 1, 0, 2)));
        head_rows.push_back(row_pred(op(MODE_PUSH, 3, 1, 48'd1000, 3)));
        head_rows.push_back(row_pred(op(MODE_PUSH, 4, 0, 0, 4)));
        // a step of exactly one second leaves the estimate alone
        head_rows.push_back(row_pred(op(MODE_PUSH, 5, 1, 48'd67536, 5)));
        head_rows.push_back(row_pred(op(MODE_PUSH, 6, 1, 48'd133071, 6)));
        head_rows.push_back(row_pred(op(MODE_PUSH, 7, 0, 48'hABCD_EF01_2345, 7)));
        head_rows.push_back(row_pred(op(MODE_PEEK, 0, 0, 0, 0)));
        head_rows.push_back(row_pred(op(MODE_POP, 0, 0, 0, 0)));
        head_rows.push_back(row_pred(op(MODE_DROP, 0, 0, 0, 0)));
        head_rows.push_back(row_lit(op(MODE_NOP6, 32'hFFFF_FFFF, 1, TS_MAX, 32'hFFFF_FFFF),
                                    ST_DONE, 0, 7));
        for (int i = 0; i < 9; i++)
            head_rows.push_back(row_pred(op(MODE_PUSH, 32'hA5A5_0000 + i, 1'(i % 2),
                                            48'h1_0000_0000 * i, 32'h5A5A_0000 ^ i)));
        head_rows.push_back(row_lit(op(MODE_PUSH, 9, 1, 9, 9), ST_FULL, 0, DEPTH));
        head_rows.push_back(row_lit(op(MODE_FLUSH, 0, 0, 0, 0), ST_DONE, 0, 0));

        // abort is sticky until reset, so it only comes at the very end
        tail_rows.push_back(row_lit(op(MODE_FLUSH, 0, 0, 0, 0), ST_DONE, 0, 0));
        tail_rows.push_back(row_lit(op(MODE_PUSH, 1, 0, 48'h77, 1), ST_DONE, 0, 1));
        tail_rows.push_back(row_lit(op(MODE_ABORT, 0, 0, 0, 0), ST_DONE, 0, 1));
        tail_rows.push_back(row_lit(op(MODE_PUSH, 2, 1, 48'h88, 2), ST_ABORT, 0, 1));
        tail_rows.push_back(row_lit(op(MODE_POP, 0, 0, 0, 0), ST_ABORT, 0, 1));
        tail_rows.push_back(row_lit(op(MODE_PEEK, 0, 0, 0, 0), ST_ABORT, 0, 1));
        tail_rows.push_back(row_lit(op(MODE_DROP, 0, 0, 0, 0), ST_DONE, 0, 0));
        tail_rows.push_back(row_lit(op(MODE_DROP, 0, 0, 0, 0), ST_EMPTY, 0, 0));
        tail_rows.push_back(row_lit(op(MODE_FLUSH, 0, 0, 0, 0), ST_DONE, 0, 0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (head_rows[i]) send_op(head_rows[i].item, head_rows[i].fixed, head_rows[i].want);
        drain_results();

        write_duration(16'd1);
        run_phase(300, 0, 0);
        write_duration(16'hFFFF);
        run_phase(250, 87, 0);
        // zero is out of range but accepted: fills repeat the last timestamp
        write_duration(16'd0);
        run_phase(250, 0, 87);
        write_duration(DUR_W'($urandom_range(1, 65535)));
        run_phase(300, 10, 10);

        // receiver holds off while the sender keeps offering beats
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        stall_go     = 1'b1;
        for (int k = 0; k < 40; k++) send_op(random_op(70), 1'b0, '0);
        drain_results();

        write_duration(DUR_RESET);
        run_phase(250, 0, 0);

        foreach (tail_rows[i]) send_op(tail_rows[i].item, tail_rows[i].fixed, tail_rows[i].want);
        drain_results();
        repeat (20) @(posedge clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
